[src/swb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the supervisor watchdog with restart backoff.
// No dependencies; used by swb_cfg and supervisor_watchdog_backoff.
package swb_pkg;

  localparam int unsigned COOLDOWN_TICKS = 60;

  // Input modes
  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_HEARTBEAT = 3'd1;
  localparam logic [2:0] MODE_STOP      = 3'd2;
  localparam logic [2:0] MODE_EXITED    = 3'd3;
  localparam logic [2:0] MODE_SIGNALED  = 3'd4;
  localparam logic [2:0] MODE_WAIT_ERR  = 3'd5;
  localparam logic [2:0] MODE_LAUNCH_FL = 3'd6;

  // Exit classes
  localparam logic [1:0] EXIT_CLEAN = 2'd0;
  localparam logic [1:0] EXIT_FATAL = 2'd1;

  // Signal kinds
  localparam logic [2:0] SIG_TERM   = 3'd0;
  localparam logic [2:0] SIG_KILL   = 3'd1;
  localparam logic [2:0] SIG_INT    = 3'd2;
  localparam logic [2:0] SIG_HANGUP = 3'd3;

  // Result actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_FWD    = 3'd1;
  localparam logic [2:0] ACT_TERM   = 3'd2;
  localparam logic [2:0] ACT_KILL   = 3'd3;
  localparam logic [2:0] ACT_LAUNCH = 3'd4;
  localparam logic [2:0] ACT_CLEAN  = 3'd5;
  localparam logic [2:0] ACT_FATAL  = 3'd6;
  localparam logic [2:0] ACT_LIMIT  = 3'd7;

  // Register indexes
  localparam logic [2:0] REG_INITIAL_DELAY = 3'd0;
  localparam logic [2:0] REG_MAX_DELAY     = 3'd1;
  localparam logic [2:0] REG_RESTART_LIMIT = 3'd2;
  localparam logic [2:0] REG_HB_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_START_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_GRACE_PERIOD  = 3'd5;
  localparam logic [2:0] REG_CRASH_WINDOW  = 3'd6;
  localparam logic [2:0] REG_CRASH_LIMIT   = 3'd7;

  localparam int unsigned ADDR_W = 5;

  // Register reset values
  localparam logic [7:0]  RST_INITIAL_DELAY = 8'd1;
  localparam logic [7:0]  RST_MAX_DELAY     = 8'd10;
  localparam logic [15:0] RST_RESTART_LIMIT = 16'd0;
  localparam logic [15:0] RST_HB_TIMEOUT    = 16'd20;
  localparam logic [15:0] RST_START_TIMEOUT = 16'd45;
  localparam logic [7:0]  RST_GRACE_PERIOD  = 8'd3;
  localparam logic [15:0] RST_CRASH_WINDOW  = 16'd60;
  localparam logic [7:0]  RST_CRASH_LIMIT   = 8'd8;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_HALT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  initial_delay;
    logic [7:0]  max_delay;
    logic [15:0] restart_limit;
    logic [15:0] heartbeat_timeout;
    logic [15:0] startup_timeout;
    logic [7:0]  grace_period;
    logic [15:0] crash_window;
    logic [7:0]  crash_limit;
  } cfg_t;

endpackage

[src/supervisor_watchdog_backoff.sv]
`timescale 1ns / 1ps
// Top level of the supervisor watchdog with exponential restart backoff.
// Depends on swb_pkg and swb_cfg.
//
// Usage:
//  - Input channel (in_valid / in_stall, in_mode, in_exit_class, in_signal_kind):
//    one transaction per event (tick, heartbeat, stop request, exit, signal,
//    wait error, launch failure).
//  - Output channel (out_valid / out_stall): exactly one transaction per input
//    transaction: action, forwarded signal, restart total, current delay.
//  - APB port sets the eight timing/limit registers; write only while idle.
//  - The result passes through the input register, then the result register;
//    the receiver can take it at the next edge. Throughput: one transaction
//    per cycle while out_stall is low; the state update is a single pass of
//    compares and counter increments.
//  - The input register accepts a new transaction while a finished result
//    waits in the output register; in_stall rises only when both are full
//    and out_stall holds the result.
//  - Reset (rst_n low, synchronous) empties both stages, returns the
//    registers to their defaults and the supervisor to waiting with no
//    delay, so the first tick launches.
module supervisor_watchdog_backoff (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_mode,
  input  logic [1:0]                 in_exit_class,
  input  logic [2:0]                 in_signal_kind,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_action,
  output logic [2:0]                 out_forwarded_signal,
  output logic [15:0]                out_restart_total,
  output logic [7:0]                 out_current_delay,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import swb_pkg::*;

  cfg_t cfg;

  swb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------- handshake / input register ----------------
  logic       inq_valid_r;
  logic [2:0] inq_mode_r;
  logic [1:0] inq_ecls_r;
  logic [2:0] inq_sig_r;
  logic       advance;
  logic       in_take;

  // item in the input register moves on when the result register frees up
  assign advance  = inq_valid_r && (!out_valid || !out_stall);
  assign in_stall = inq_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_take) begin
      inq_valid_r <= 1'b1;
    end else if (advance) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_mode_r <= in_mode;
      inq_ecls_r <= in_exit_class;
      inq_sig_r  <= in_signal_kind;
    end
  end

  // ---------------- supervisor state ----------------
  phase_t      phase_r, phase_nxt;
  logic [7:0]  wait_left_r, wait_left_nxt;
  logic        cooling_r, cooling_nxt;
  logic [15:0] uptime_r, uptime_nxt;
  logic [15:0] hb_age_r, hb_age_nxt;
  logic        saw_hb_r, saw_hb_nxt;
  logic        rst_pend_r, rst_pend_nxt;
  logic        term_r, term_nxt;
  logic        kill_r, kill_nxt;
  logic [7:0]  grace_r, grace_nxt;
  logic        stop_req_r, stop_req_nxt;
  logic [15:0] rcount_r, rcount_nxt;
  logic [7:0]  backoff_r, backoff_nxt;
  logic [31:0] ticks_r, ticks_nxt;
  logic [31:0] win_start_r, win_start_nxt;
  logic        win_valid_r, win_valid_nxt;
  logic [7:0]  win_cnt_r, win_cnt_nxt;

  // ---------------- restart scheduling (from current state) ----------------
  logic [15:0] sr_rcount;
  logic        sr_limit;
  logic [31:0] sr_t_launch;
  logic [31:0] sr_win_age;
  logic        sr_new_win;
  logic [7:0]  sr_win_base;
  logic [7:0]  sr_win_cnt;
  logic [7:0]  sr_bd_base;
  logic        sr_cool;
  logic [8:0]  sr_dbl;
  logic [7:0]  sr_bd_next;

  always_comb begin
    sr_rcount   = (rcount_r == 16'hFFFF) ? rcount_r : rcount_r + 16'd1;
    sr_limit    = (cfg.restart_limit != 16'd0) && (sr_rcount >= cfg.restart_limit);
    // launch time goes late once uptime saturates; kept as is
    sr_t_launch = ticks_r - {16'd0, uptime_r};
    sr_win_age  = sr_t_launch - win_start_r;
    sr_new_win  = !win_valid_r || (sr_win_age > {16'd0, cfg.crash_window});
    sr_win_base = sr_new_win ? 8'd0 : win_cnt_r;
    sr_win_cnt  = (sr_win_base == 8'hFF) ? sr_win_base : sr_win_base + 8'd1;
    // long uptime restores the initial backoff
    sr_bd_base  = (uptime_r >= {8'd0, cfg.max_delay}) ? cfg.initial_delay : backoff_r;
    sr_cool     = sr_win_cnt >= cfg.crash_limit;
    sr_dbl      = {sr_bd_base, 1'b0};
    sr_bd_next  = (sr_dbl > {1'b0, cfg.max_delay}) ? cfg.max_delay : sr_dbl[7:0];
  end

  // ---------------- per-item next state ----------------
  logic [2:0] act;
  logic [2:0] fwd;
  logic       run;
  logic       live;
  logic       kill_check;
  logic       do_restart;
  logic       sig_stop_ok;

  always_comb begin
    phase_nxt     = phase_r;
    wait_left_nxt = wait_left_r;
    cooling_nxt   = cooling_r;
    uptime_nxt    = uptime_r;
    hb_age_nxt    = hb_age_r;
    saw_hb_nxt    = saw_hb_r;
    rst_pend_nxt  = rst_pend_r;
    term_nxt      = term_r;
    kill_nxt      = kill_r;
    grace_nxt     = grace_r;
    stop_req_nxt  = stop_req_r;
    rcount_nxt    = rcount_r;
    backoff_nxt   = backoff_r;
    ticks_nxt     = ticks_r;
    win_start_nxt = win_start_r;
    win_valid_nxt = win_valid_r;
    win_cnt_nxt   = win_cnt_r;
    act           = ACT_NONE;
    fwd           = 3'd0;
    kill_check    = 1'b0;
    do_restart    = 1'b0;

    run  = (phase_r == PH_RUN);
    live = (phase_r == PH_WAIT) || run;
    sig_stop_ok = (inq_sig_r == SIG_TERM) || (inq_sig_r == SIG_INT) ||
                  (inq_sig_r == SIG_HANGUP);

    if (live) begin
      case (inq_mode_r)
        MODE_TICK: begin
          ticks_nxt = ticks_r + 32'd1;
          if (run) begin
            uptime_nxt = (uptime_r == 16'hFFFF) ? uptime_r : uptime_r + 16'd1;
            hb_age_nxt = (hb_age_r == 16'hFFFF) ? hb_age_r : hb_age_r + 16'd1;
            if (term_r && !kill_r) begin
              grace_nxt = (grace_r == 8'hFF) ? grace_r : grace_r + 8'd1;
            end
            if (stop_req_r) begin
              if (!term_r) begin
                term_nxt  = 1'b1;
                grace_nxt = 8'd0;
                act       = ACT_TERM;
              end else begin
                kill_check = 1'b1;
              end
            end else if (!rst_pend_r) begin
              if ((!saw_hb_r && uptime_nxt >= cfg.startup_timeout) ||
                  (saw_hb_r && hb_age_nxt >= cfg.heartbeat_timeout)) begin
                rst_pend_nxt = 1'b1;
                term_nxt     = 1'b1;
                grace_nxt    = 8'd0;
                act          = ACT_TERM;
              end
            end else begin
              kill_check = 1'b1;
            end
            // grace over after terminate: escalate to kill
            if (kill_check && term_r && !kill_r && grace_nxt >= cfg.grace_period) begin
              kill_nxt = 1'b1;
              act      = ACT_KILL;
            end
          end else begin
            wait_left_nxt = (wait_left_r != 8'd0) ? wait_left_r - 8'd1 : 8'd0;
            if (wait_left_nxt == 8'd0) begin
              if (cooling_r) begin
                win_start_nxt = ticks_nxt;
                win_cnt_nxt   = 8'd0;
                cooling_nxt   = 1'b0;
              end
              phase_nxt    = PH_RUN;
              uptime_nxt   = 16'd0;
              hb_age_nxt   = 16'd0;
              saw_hb_nxt   = 1'b0;
              rst_pend_nxt = 1'b0;
              term_nxt     = 1'b0;
              kill_nxt     = 1'b0;
              grace_nxt    = 8'd0;
              act          = ACT_LAUNCH;
            end
          end
        end
        MODE_HEARTBEAT: begin
          if (run) begin
            hb_age_nxt = 16'd0;
            saw_hb_nxt = 1'b1;
          end
        end
        MODE_STOP: begin
          if (sig_stop_ok) begin
            stop_req_nxt = 1'b1;
            if (run) begin
              act = ACT_FWD;
              fwd = inq_sig_r;
            end
          end
        end
        MODE_EXITED: begin
          if (run) begin
            if (inq_ecls_r == EXIT_CLEAN) begin
              phase_nxt = PH_HALT;
              act       = ACT_CLEAN;
            end else if (inq_ecls_r == EXIT_FATAL) begin
              phase_nxt = PH_HALT;
              act       = ACT_FATAL;
            end else begin
              do_restart = 1'b1;
            end
          end
        end
        MODE_SIGNALED: begin
          if (run) begin
            // expected death after our own stop, or a plain term
            if ((stop_req_r && (inq_sig_r == SIG_TERM || inq_sig_r == SIG_KILL)) ||
                (!rst_pend_r && inq_sig_r == SIG_TERM)) begin
              phase_nxt = PH_HALT;
              act       = ACT_CLEAN;
            end else begin
              do_restart = 1'b1;
            end
          end
        end
        MODE_WAIT_ERR: begin
          if (run) begin
            rst_pend_nxt = 1'b1;
            if (!kill_r) begin
              kill_nxt = 1'b1;
              act      = ACT_KILL;
            end
          end
        end
        MODE_LAUNCH_FL: begin
          if (run) begin
            phase_nxt     = PH_WAIT;
            wait_left_nxt = backoff_r;
          end
        end
        default: ;
      endcase
    end

    if (do_restart) begin
      rcount_nxt = sr_rcount;
      if (sr_limit) begin
        phase_nxt = PH_HALT;
        act       = ACT_LIMIT;
      end else begin
        if (sr_new_win) begin
          win_start_nxt = sr_t_launch;
        end
        win_valid_nxt = 1'b1;
        win_cnt_nxt   = sr_win_cnt;
        phase_nxt     = PH_WAIT;
        if (sr_cool) begin
          // too many restarts in the window: fixed cooldown
          wait_left_nxt = 8'(COOLDOWN_TICKS);
          cooling_nxt   = 1'b1;
          backoff_nxt   = cfg.initial_delay;
        end else begin
          wait_left_nxt = sr_bd_base;
          backoff_nxt   = sr_bd_next;
        end
        act = ACT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      wait_left_r <= 8'd0;
      cooling_r   <= 1'b0;
      uptime_r    <= 16'd0;
      hb_age_r    <= 16'd0;
      saw_hb_r    <= 1'b0;
      rst_pend_r  <= 1'b0;
      term_r      <= 1'b0;
      kill_r      <= 1'b0;
      grace_r     <= 8'd0;
      stop_req_r  <= 1'b0;
      rcount_r    <= 16'd0;
      backoff_r   <= RST_INITIAL_DELAY;
      ticks_r     <= 32'd0;
      win_start_r <= 32'd0;
      win_valid_r <= 1'b0;
      win_cnt_r   <= 8'd0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      wait_left_r <= wait_left_nxt;
      cooling_r   <= cooling_nxt;
      uptime_r    <= uptime_nxt;
      hb_age_r    <= hb_age_nxt;
      saw_hb_r    <= saw_hb_nxt;
      rst_pend_r  <= rst_pend_nxt;
      term_r      <= term_nxt;
      kill_r      <= kill_nxt;
      grace_r     <= grace_nxt;
      stop_req_r  <= stop_req_nxt;
      rcount_r    <= rcount_nxt;
      backoff_r   <= backoff_nxt;
      ticks_r     <= ticks_nxt;
      win_start_r <= win_start_nxt;
      win_valid_r <= win_valid_nxt;
      win_cnt_r   <= win_cnt_nxt;
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_r;
  logic [2:0]  out_action_r;
  logic [2:0]  out_fwd_r;
  logic [15:0] out_total_r;
  logic [7:0]  out_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action_r <= act;
      out_fwd_r    <= fwd;
      out_total_r  <= rcount_nxt;
      out_delay_r  <= backoff_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action           = out_action_r;
  assign out_forwarded_signal = out_fwd_r;
  assign out_restart_total    = out_total_r;
  assign out_current_delay    = out_delay_r;

endmodule

[src/swb_cfg.sv]
`timescale 1ns / 1ps
// APB register file for the watchdog settings.
// Depends on swb_pkg (cfg_t, register indexes, reset values).
module swb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output swb_pkg::cfg_t              cfg
);
  import swb_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_delay     <= RST_INITIAL_DELAY;
      cfg_r.max_delay         <= RST_MAX_DELAY;
      cfg_r.restart_limit     <= RST_RESTART_LIMIT;
      cfg_r.heartbeat_timeout <= RST_HB_TIMEOUT;
      cfg_r.startup_timeout   <= RST_START_TIMEOUT;
      cfg_r.grace_period      <= RST_GRACE_PERIOD;
      cfg_r.crash_window      <= RST_CRASH_WINDOW;
      cfg_r.crash_limit       <= RST_CRASH_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_INITIAL_DELAY: cfg_r.initial_delay     <= pwdata[7:0];
        REG_MAX_DELAY:     cfg_r.max_delay         <= pwdata[7:0];
        REG_RESTART_LIMIT: cfg_r.restart_limit     <= pwdata[15:0];
        REG_HB_TIMEOUT:    cfg_r.heartbeat_timeout <= pwdata[15:0];
        REG_START_TIMEOUT: cfg_r.startup_timeout   <= pwdata[15:0];
        REG_GRACE_PERIOD:  cfg_r.grace_period      <= pwdata[7:0];
        REG_CRASH_WINDOW:  cfg_r.crash_window      <= pwdata[15:0];
        REG_CRASH_LIMIT:   cfg_r.crash_limit       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INITIAL_DELAY: prdata = {24'd0, cfg_r.initial_delay};
      REG_MAX_DELAY:     prdata = {24'd0, cfg_r.max_delay};
      REG_RESTART_LIMIT: prdata = {16'd0, cfg_r.restart_limit};
      REG_HB_TIMEOUT:    prdata = {16'd0, cfg_r.heartbeat_timeout};
      REG_START_TIMEOUT: prdata = {16'd0, cfg_r.startup_timeout};
      REG_GRACE_PERIOD:  prdata = {24'd0, cfg_r.grace_period};
      REG_CRASH_WINDOW:  prdata = {16'd0, cfg_r.crash_window};
      REG_CRASH_LIMIT:   prdata = {24'd0, cfg_r.crash_limit};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

[tb/supervisor_watchdog_backoff_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for supervisor_watchdog_backoff: directed and random event
// streams against a behavioral watchdog predictor, with random stalls on both sides.
// Depends on swb_pkg and the supervisor_watchdog_backoff RTL.
module supervisor_watchdog_backoff_tb;
  import swb_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [1:0] EXIT_OTHER  = 2'd2;
  localparam logic [1:0] EXIT_ODD    = 2'd3;
  localparam logic [2:0] SIG_OTHER   = 3'd4;
  localparam logic [2:0] SIG_BAD     = 3'd7;

  // One input transaction
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] ecls;
    logic [2:0] sig;
  } sup_item_t;

  // One result transaction
  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  fwd;
    logic [15:0] total;
    logic [7:0]  delay;
  } verdict_t;

  // Supervisor state as the predictor tracks it
  typedef struct {
    phase_t      phase;
    logic [7:0]  wait_left;
    logic        cooling;
    logic [15:0] uptime;
    logic [15:0] hb_age;
    logic        saw_hb;
    logic        pending;
    logic        term;
    logic        kill;
    logic [7:0]  grace;
    logic        stop_req;
    logic [15:0] restarts;
    logic [7:0]  backoff;
    logic [31:0] ticks;
    logic [31:0] win_start;
    logic        win_valid;
    logic [7:0]  win_restarts;
  } sup_state_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          in_mode;
  logic [1:0]          in_exit_class;
  logic [2:0]          in_signal_kind;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          out_action;
  logic [2:0]          out_forwarded_signal;
  logic [15:0]         out_restart_total;
  logic [7:0]          out_current_delay;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // live_*: tracks what the DUT has accepted; plan_*: tracks what has been queued,
  // so the generator can steer around shutdowns until the end of the run.
  sup_state_t          live_state;
  sup_state_t          plan_state;
  cfg_t                live_cfg;
  cfg_t                plan_cfg;

  sup_item_t           pending_items[$];
  verdict_t            expected_verdicts[$];
  verdict_t            want_v;

  int unsigned         error_count;
  int unsigned         accept_count;
  int unsigned         taken_seen;
  int unsigned         in_gap;
  int unsigned         out_hold;
  int unsigned         hb_pct;
  logic                idle_on;
  logic                halt_ok;
  logic                stop_ok;

  supervisor_watchdog_backoff DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_exit_class        (in_exit_class),
    .in_signal_kind       (in_signal_kind),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_forwarded_signal (out_forwarded_signal),
    .out_restart_total    (out_restart_total),
    .out_current_delay    (out_current_delay),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic sup_state_t fresh_state();
    sup_state_t s;
    s.phase        = PH_WAIT;
    s.wait_left    = '0;
    s.cooling      = 1'b0;
    s.uptime       = '0;
    s.hb_age       = '0;
    s.saw_hb       = 1'b0;
    s.pending      = 1'b0;
    s.term         = 1'b0;
    s.kill         = 1'b0;
    s.grace        = '0;
    s.stop_req     = 1'b0;
    s.restarts     = '0;
    s.backoff      = RST_INITIAL_DELAY;
    s.ticks        = '0;
    s.win_start    = '0;
    s.win_valid    = 1'b0;
    s.win_restarts = '0;
    return s;
  endfunction

  // Unit ended with a restartable status: count it, maybe give up, maybe cool down,
  // otherwise wait out the current backoff and double it for next time.
  function automatic logic [2:0] count_restart(inout sup_state_t s, input cfg_t c);
    logic [31:0] launched;
    int unsigned doubled;
    // launch time is inferred from uptime, so it drifts late once uptime saturates
    launched = s.ticks - {16'h0, s.uptime};
    if (s.restarts != 16'hFFFF) s.restarts = s.restarts + 1'b1;
    if (c.restart_limit != 16'd0 && s.restarts >= c.restart_limit) begin
      s.phase = PH_HALT;
      return ACT_LIMIT;
    end
    if (!s.win_valid || (launched - s.win_start) > {16'h0, c.crash_window}) begin
      s.win_start    = launched;
      s.win_restarts = '0;
      s.win_valid    = 1'b1;
    end
    if (s.win_restarts != 8'hFF) s.win_restarts = s.win_restarts + 1'b1;
    // long-lived run: backoff starts over
    if (s.uptime >= c.max_delay) s.backoff = c.initial_delay;
    s.phase = PH_WAIT;
    if (s.win_restarts >= c.crash_limit) begin
      s.wait_left = 8'(COOLDOWN_TICKS);
      s.cooling   = 1'b1;
      s.backoff   = c.initial_delay;
      return ACT_NONE;
    end
    s.wait_left = s.backoff;
    doubled     = 32'(s.backoff) * 2;
    s.backoff   = (doubled > c.max_delay) ? c.max_delay : 8'(doubled);
    return ACT_NONE;
  endfunction

  // Applies one transaction to the state and returns the result it produces.
  function automatic verdict_t supervise(inout sup_state_t s, input cfg_t c,
                                         input logic [2:0] mode, input logic [1:0] ecls,
                                         input logic [2:0] sig);
    verdict_t v;
    logic     running;
    logic     stop_kind;
    v         = '0;
    running   = (s.phase == PH_RUN);
    stop_kind = (sig == SIG_TERM || sig == SIG_INT || sig == SIG_HANGUP);
    if (s.phase == PH_WAIT || running) begin
      case (mode)
        MODE_TICK: begin
          s.ticks = s.ticks + 1;
          if (running) begin
            if (s.uptime != 16'hFFFF) s.uptime = s.uptime + 1'b1;
            if (s.hb_age != 16'hFFFF) s.hb_age = s.hb_age + 1'b1;
            if (s.term && !s.kill && s.grace != 8'hFF) s.grace = s.grace + 1'b1;
            if (s.stop_req && !s.term) begin
              s.term   = 1'b1;
              s.grace  = '0;
              v.action = ACT_TERM;
            end else if (!s.stop_req && !s.pending) begin
              // startup timeout before the first heartbeat, heartbeat timeout after it
              if ((!s.saw_hb && s.uptime >= c.startup_timeout) ||
                  (s.saw_hb && s.hb_age >= c.heartbeat_timeout)) begin
                s.pending = 1'b1;
                s.term    = 1'b1;
                s.grace   = '0;
                v.action  = ACT_TERM;
              end
            end else if (s.term && !s.kill && s.grace >= c.grace_period) begin
              s.kill   = 1'b1;
              v.action = ACT_KILL;
            end
          end else begin
            if (s.wait_left != 8'd0) s.wait_left = s.wait_left - 1'b1;
            if (s.wait_left == 8'd0) begin
              // end of cooldown opens a fresh crash window
              if (s.cooling) begin
                s.win_start    = s.ticks;
                s.win_restarts = '0;
                s.cooling      = 1'b0;
              end
              s.phase   = PH_RUN;
              s.uptime  = '0;
              s.hb_age  = '0;
              s.saw_hb  = 1'b0;
              s.pending = 1'b0;
              s.term    = 1'b0;
              s.kill    = 1'b0;
              s.grace   = '0;
              v.action  = ACT_LAUNCH;
            end
          end
        end
        MODE_HEARTBEAT: begin
          if (running) begin
            s.hb_age = '0;
            s.saw_hb = 1'b1;
          end
        end
        MODE_STOP: begin
          // sticky: once set, every later run gets terminated
          if (stop_kind) begin
            s.stop_req = 1'b1;
            if (running) begin
              v.action = ACT_FWD;
              v.fwd    = sig;
            end
          end
        end
        MODE_EXITED: begin
          if (running) begin
            if (ecls == EXIT_CLEAN) begin
              s.phase  = PH_HALT;
              v.action = ACT_CLEAN;
            end else if (ecls == EXIT_FATAL) begin
              s.phase  = PH_HALT;
              v.action = ACT_FATAL;
            end else begin
              v.action = count_restart(s, c);
            end
          end
        end
        MODE_SIGNALED: begin
          if (running) begin
            if ((s.stop_req && (sig == SIG_TERM || sig == SIG_KILL)) ||
                (!s.pending && sig == SIG_TERM)) begin
              s.phase  = PH_HALT;
              v.action = ACT_CLEAN;
            end else begin
              v.action = count_restart(s, c);
            end
          end
        end
        MODE_WAIT_ERR: begin
          if (running) begin
            s.pending = 1'b1;
            if (!s.kill) begin
              s.kill   = 1'b1;
              v.action = ACT_KILL;
            end
          end
        end
        MODE_LAUNCH_FL: begin
          // relaunch after the current backoff; not counted as a restart
          if (running) begin
            s.phase     = PH_WAIT;
            s.wait_left = s.backoff;
          end
        end
        default: ;
      endcase
    end
    v.total = s.restarts;
    v.delay = s.backoff;
    return v;
  endfunction

  // Queue a transaction. Shutdowns (and accepted stop requests, which never clear)
  // are held back until the closing part of the run; a shutdown becomes a tick.
  function automatic void queue_item(input logic [2:0] mode, input logic [1:0] ecls,
                                     input logic [2:0] sig);
    sup_item_t  it;
    sup_state_t trial;
    it = {mode, ecls, sig};
    if (!stop_ok && it.mode == MODE_STOP &&
        (it.sig == SIG_TERM || it.sig == SIG_INT || it.sig == SIG_HANGUP))
      it.sig = SIG_KILL;
    trial = plan_state;
    void'(supervise(trial, plan_cfg, it.mode, it.ecls, it.sig));
    if (!halt_ok && trial.phase == PH_HALT) begin
      it    = {MODE_TICK, EXIT_CLEAN, SIG_TERM};
      trial = plan_state;
      void'(supervise(trial, plan_cfg, it.mode, it.ecls, it.sig));
    end
    plan_state = trial;
    pending_items.push_back(it);
  endfunction

  // Mostly well-formed traffic for the current phase, with some raw noise.
  function automatic sup_item_t draw_item();
    sup_item_t   it;
    int unsigned r;
    it.mode = 3'($urandom_range(0, 7));
    it.ecls = 2'($urandom_range(0, 3));
    it.sig  = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (plan_state.phase == PH_WAIT) begin
      if (r < 85) it.mode = MODE_TICK;
    end else if (plan_state.phase == PH_RUN && r >= 8) begin
      r = $urandom_range(0, 99);
      if (r < hb_pct)            it.mode = MODE_HEARTBEAT;
      else if (r < hb_pct + 6)   it.mode = MODE_EXITED;
      else if (r < hb_pct + 12)  it.mode = MODE_SIGNALED;
      else if (r < hb_pct + 16)  it.mode = MODE_WAIT_ERR;
      else if (r < hb_pct + 19)  it.mode = MODE_LAUNCH_FL;
      else if (r < hb_pct + 24)  it.mode = MODE_STOP;
      else                       it.mode = MODE_TICK;
    end
    return it;
  endfunction

  function automatic cfg_t rand_config();
    cfg_t c;
    c.initial_delay     = 8'($urandom_range(0, 12));
    c.max_delay         = 8'($urandom_range(1, 40));
    c.restart_limit     = 16'd0;
    c.heartbeat_timeout = 16'($urandom_range(1, 30));
    c.startup_timeout   = 16'($urandom_range(1, 50));
    c.grace_period      = 8'($urandom_range(0, 10));
    c.crash_window      = 16'($urandom_range(1, 200));
    c.crash_limit       = 8'($urandom_range(1, 10));
    return c;
  endfunction

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_INITIAL_DELAY: live_cfg.initial_delay     = val[7:0];
      REG_MAX_DELAY:     live_cfg.max_delay         = val[7:0];
      REG_RESTART_LIMIT: live_cfg.restart_limit     = val[15:0];
      REG_HB_TIMEOUT:    live_cfg.heartbeat_timeout = val[15:0];
      REG_START_TIMEOUT: live_cfg.startup_timeout   = val[15:0];
      REG_GRACE_PERIOD:  live_cfg.grace_period      = val[7:0];
      REG_CRASH_WINDOW:  live_cfg.crash_window      = val[15:0];
      REG_CRASH_LIMIT:   live_cfg.crash_limit       = val[7:0];
      default: ;
    endcase
    plan_cfg = live_cfg;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != val)
      note_mismatch($sformatf("reg %0d reads 0x%0h, wrote 0x%0h", idx, prdata, val));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_INITIAL_DELAY, {24'h0, c.initial_delay});
    write_reg(REG_MAX_DELAY,     {24'h0, c.max_delay});
    write_reg(REG_RESTART_LIMIT, {16'h0, c.restart_limit});
    write_reg(REG_HB_TIMEOUT,    {16'h0, c.heartbeat_timeout});
    write_reg(REG_START_TIMEOUT, {16'h0, c.startup_timeout});
    write_reg(REG_GRACE_PERIOD,  {24'h0, c.grace_period});
    write_reg(REG_CRASH_WINDOW,  {16'h0, c.crash_window});
    write_reg(REG_CRASH_LIMIT,   {24'h0, c.crash_limit});
  endtask

  // Block is idle once every queued transaction has been answered.
  task automatic drain();
    while (pending_items.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned n, input logic closing);
    sup_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      // shutdowns only allowed in the tail of the closing phase
      if (closing && i + 40 >= n) halt_ok = 1'b1;
      it = draw_item();
      queue_item(it.mode, it.ecls, it.sig);
    end
    drain();
  endtask

  // Input side: accepted transactions feed the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_verdicts.push_back(supervise(live_state, live_cfg, in_mode,
                                            in_exit_class, in_signal_kind));
      void'(pending_items.pop_front());
      accept_count++;
    end
  end

  // Driver: moves to the next transaction only after the current one is taken,
  // with random idle bursts between transactions.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accept_count != taken_seen) begin
      taken_seen = accept_count;
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else begin
        in_valid       <= 1'b1;
        in_mode        <= pending_items[0].mode;
        in_exit_class  <= pending_items[0].ecls;
        in_signal_kind <= pending_items[0].sig;
      end
    end
  end

  // Back-pressure on the result channel, in random bursts.
  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_hold = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: each result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch($sformatf("unexpected result action %0d", out_action));
      end else begin
        want_v = expected_verdicts.pop_front();
        if (out_action != want_v.action)
          note_mismatch($sformatf("action %0d, want %0d", out_action, want_v.action));
        if (out_forwarded_signal != want_v.fwd)
          note_mismatch($sformatf("forwarded_signal %0d, want %0d",
                                  out_forwarded_signal, want_v.fwd));
        if (out_restart_total != want_v.total)
          note_mismatch($sformatf("restart_total %0d, want %0d",
                                  out_restart_total, want_v.total));
        if (out_current_delay != want_v.delay)
          note_mismatch($sformatf("current_delay %0d, want %0d",
                                  out_current_delay, want_v.delay));
      end
    end
  end

  // Run limit: sized well past the slowest legal run (~600 transactions with
  // the longest idle and stall bursts, plus the register writes).
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cfg_t c;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_TICK;
    in_exit_class  = EXIT_CLEAN;
    in_signal_kind = SIG_TERM;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    error_count    = 0;
    accept_count   = 0;
    taken_seen     = 0;
    in_gap         = 0;
    out_hold       = 0;
    hb_pct         = 25;
    idle_on        = 1'b1;
    halt_ok        = 1'b0;
    stop_ok        = 1'b0;
    live_state     = fresh_state();
    plan_state     = fresh_state();
    live_cfg       = {RST_INITIAL_DELAY, RST_MAX_DELAY, RST_RESTART_LIMIT, RST_HB_TIMEOUT,
                      RST_START_TIMEOUT, RST_GRACE_PERIOD, RST_CRASH_WINDOW, RST_CRASH_LIMIT};
    plan_cfg       = live_cfg;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset config. Events while waiting are all ignored.
    queue_item(MODE_HEARTBEAT, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_EXITED,    EXIT_ODD,   SIG_TERM);
    queue_item(MODE_SIGNALED,  EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_WAIT_ERR,  EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_LAUNCH_FL, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_UNUSED,    EXIT_ODD,   SIG_BAD);
    queue_item(MODE_STOP,      EXIT_CLEAN, SIG_KILL);   // not a stop kind
    queue_item(MODE_STOP,      EXIT_CLEAN, SIG_OTHER);
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);   // zero wait: launch
    queue_item(MODE_HEARTBEAT, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_STOP,      EXIT_ODD,   SIG_BAD);
    queue_item(MODE_UNUSED,    EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_WAIT_ERR,  EXIT_CLEAN, SIG_TERM);   // kill once
    queue_item(MODE_WAIT_ERR,  EXIT_CLEAN, SIG_TERM);   // already killed
    queue_item(MODE_SIGNALED,  EXIT_CLEAN, SIG_INT);    // restart
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_LAUNCH_FL, EXIT_CLEAN, SIG_TERM);   // back to waiting, no count
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_EXITED,    EXIT_ODD,   SIG_TERM);   // odd class counts as other
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_SIGNALED,  EXIT_OTHER, SIG_OTHER);
    random_phase(70, 1'b0);

    // Widest backoff range, no grace, huge crash window
    c = '{initial_delay: 8'd1, max_delay: 8'd255, restart_limit: 16'd0,
          heartbeat_timeout: 16'd3, startup_timeout: 16'd5, grace_period: 8'd0,
          crash_window: 16'hFFFF, crash_limit: 8'd255};
    load_config(c);
    hb_pct = 20;
    random_phase(75, 1'b0);

    // Tightest timeouts, longest grace; every restart forces a cooldown
    c = '{initial_delay: 8'd0, max_delay: 8'd1, restart_limit: 16'hFFFF,
          heartbeat_timeout: 16'd1, startup_timeout: 16'd1, grace_period: 8'd255,
          crash_window: 16'd1, crash_limit: 8'd1};
    load_config(c);
    hb_pct = 40;
    random_phase(75, 1'b0);

    load_config(rand_config());
    hb_pct = $urandom_range(0, 35);
    random_phase(80, 1'b0);

    load_config(rand_config());
    hb_pct = $urandom_range(0, 35);
    random_phase(80, 1'b0);

    // Long quiet run with the timeouts out of reach, then a restart after an
    // uptime past the backoff ceiling. No idling from here on.
    c = rand_config();
    c.heartbeat_timeout = 16'hFFFF;
    c.startup_timeout   = 16'hFFFF;
    load_config(c);
    idle_on = 1'b0;
    while (plan_state.phase != PH_RUN) queue_item(MODE_TICK, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_HEARTBEAT, EXIT_CLEAN, SIG_TERM);
    repeat (45) queue_item(MODE_TICK, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_EXITED, EXIT_OTHER, SIG_TERM);
    repeat (4) queue_item(MODE_TICK, EXIT_CLEAN, SIG_TERM);
    drain();

    // Closing phase: stop requests allowed, optional restart limit, then shutdown.
    c = rand_config();
    if ($urandom_range(0, 1) == 1)
      c.restart_limit = (plan_state.restarts > 16'hFFFC) ? 16'hFFFF :
                        plan_state.restarts + 16'($urandom_range(1, 3));
    load_config(c);
    hb_pct  = $urandom_range(5, 30);
    stop_ok = 1'b1;
    random_phase(90, 1'b1);
    while (plan_state.phase != PH_HALT) begin
      if (plan_state.phase == PH_RUN)
        queue_item(MODE_EXITED, 2'($urandom_range(0, 1)), SIG_TERM);
      else
        queue_item(MODE_TICK, EXIT_CLEAN, SIG_TERM);
    end
    // Shut down for good: everything is ignored from here on
    queue_item(MODE_TICK,      EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_HEARTBEAT, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_STOP,      EXIT_CLEAN, SIG_HANGUP);
    queue_item(MODE_SIGNALED,  EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_LAUNCH_FL, EXIT_CLEAN, SIG_TERM);
    queue_item(MODE_UNUSED,    EXIT_ODD,   SIG_BAD);
    drain();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
